// ===== sv/segment_endpoint_matcher_macros.svh =====
// Assertion macros shared by the segment endpoint matcher RTL.
`ifndef SEGMENT_ENDPOINT_MATCHER_MACROS_SVH
`define SEGMENT_ENDPOINT_MATCHER_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SEM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sem_pkg.sv =====
// Types, constants and codes for the segment endpoint matcher.
`default_nettype none

package sem_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COORD_BITS  = 12;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DIST_LAT    = 3;
  localparam int STEP_W      = $clog2(TABLE_DEPTH + DIST_LAT);
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int SUM_W       = SQ_W + 2;
  localparam int THR_W       = 26;
  localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int FUNC_W      = 2;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(500);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

  // Register index, taken from the word part of paddr.
  localparam logic REG_IDX_THRESH = 1'b0;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } seg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    coord_t            seg_x0;
    coord_t            seg_y0;
    coord_t            seg_x1;
    coord_t            seg_y1;
  } in_item_t;

  typedef struct packed {
    coord_t out_x0;
    coord_t out_y0;
    coord_t out_x1;
    coord_t out_y1;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== sv/sem_cell.sv =====
// One table cell: holds a reference segment, shifts up on append, rotates down on test.
`default_nettype none

module sem_cell
  import sem_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  seg_t       prev_i,
  input  seg_t       next_i,
  output seg_t       seg_o
);

  seg_t seg_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      seg_q <= prev_i;
    end else if (ctrl_i.rotate) begin
      seg_q <= next_i;
    end
  end

  assign seg_o = seg_q;

endmodule

`default_nettype wire

// ===== sv/sem_dist.sv =====
// Pipelined distance unit: forward and reversed endpoint measures against the threshold.
`default_nettype none

module sem_dist
  import sem_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  seg_t              seg_i,
  input  seg_t              ref_i,
  input  wire [THR_W-1:0]   thr_i,
  output logic              hit_o
);

  function automatic coord_t abs_diff(coord_t a, coord_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  coord_t            diff_d [8];
  coord_t            diff_q [8];
  logic [SQ_W-1:0]   sq_q   [8];
  logic              v1_q, v2_q, hit_q;
  logic [SUM_W-1:0]  fwd_sum, rev_sum;

  // Entries 0..3 pair endpoints forward, 4..7 reversed.
  always_comb begin
    diff_d[0] = abs_diff(seg_i.x0, ref_i.x0);
    diff_d[1] = abs_diff(seg_i.y0, ref_i.y0);
    diff_d[2] = abs_diff(seg_i.x1, ref_i.x1);
    diff_d[3] = abs_diff(seg_i.y1, ref_i.y1);
    diff_d[4] = abs_diff(seg_i.x0, ref_i.x1);
    diff_d[5] = abs_diff(seg_i.y0, ref_i.y1);
    diff_d[6] = abs_diff(seg_i.x1, ref_i.x0);
    diff_d[7] = abs_diff(seg_i.y1, ref_i.y0);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      diff_q[i] <= diff_d[i];
      sq_q[i]   <= SQ_W'(diff_q[i]) * SQ_W'(diff_q[i]);
    end
  end

  always_comb begin
    fwd_sum = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);
    rev_sum = SUM_W'(sq_q[4]) + SUM_W'(sq_q[5]) + SUM_W'(sq_q[6]) + SUM_W'(sq_q[7]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      hit_q <= v2_q && ((CMP_W'(fwd_sum) < CMP_W'(thr_i)) ||
                        (CMP_W'(rev_sum) < CMP_W'(thr_i)));
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

// ===== sv/segment_endpoint_matcher.sv =====
// Clear and append are accepted only in the idle state; a test rotates the table ring
// once past the distance unit and then waits for its 3 stages to drain.
// An unmatched segment then moves into the output register once that is free.
// Throughput: one item at a time; the rotating cell ring sets the test rate.
// Reset (rst_ni low, async): table empty, threshold 500, no result pending;
// table contents are not cleared.
`default_nettype none
`include "segment_endpoint_matcher_macros.svh"

module segment_endpoint_matcher
  import sem_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output out_item_t          out_item_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [THR_W-1:0]  thr_q;
  logic              matched_q, matched_d;
  logic              out_valid_q;
  out_item_t         out_item_q;
  seg_t              test_q;
  seg_t              in_seg;
  seg_t              cell_seg [TABLE_DEPTH];
  cell_ctrl_t        cell_ctrl;
  logic              accept, start_test, do_append, do_clear;
  logic              rotating, feed_valid, last_step, emit_load, out_free, hit;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[PADDR_W-1] == REG_IDX_THRESH)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_IDX_THRESH) begin
      prdata = PDATA_W'(thr_q);
    end
  end

  // ---------------- decode ----------------
  assign in_seg = '{x0: in_item_i.seg_x0, y0: in_item_i.seg_y0,
                    x1: in_item_i.seg_x1, y1: in_item_i.seg_y1};
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    do_clear   = 1'b0;
    do_append  = 1'b0;
    start_test = 1'b0;
    if (accept) begin
      case (in_item_i.func)
        FUNC_CLEAR:  do_clear   = 1'b1;
        FUNC_APPEND: do_append  = (count_q != CNT_W'(TABLE_DEPTH));
        FUNC_TEST:   start_test = 1'b1;
        default:     ;
      endcase
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (step_q == STEP_W'(TABLE_DEPTH + DIST_LAT - 1));

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_test) state_d = S_RUN;
      S_RUN:  if (last_step) state_d = S_EMIT;
      S_EMIT: if (matched_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_ready_o = 1'b0;
    rotating   = 1'b0;
    feed_valid = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_RUN: begin
        rotating   = (32'(step_q) < TABLE_DEPTH);
        feed_valid = rotating && (32'(step_q) < 32'(count_q));
      end
      S_EMIT: emit_load = !matched_q && out_free;
      default: ;
    endcase
  end

  assign cell_ctrl = '{shift: do_append, rotate: rotating};

  always_comb begin
    count_d = count_q;
    if (do_clear) begin
      count_d = '0;
    end else if (do_append) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    step_d    = step_q;
    matched_d = matched_q;
    if (start_test) begin
      step_d    = '0;
      matched_d = 1'b0;
    end else if (state_q == S_RUN) begin
      step_d    = step_q + STEP_W'(1);
      matched_d = matched_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      matched_q <= matched_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_test) begin
      test_q <= in_seg;
    end
    if (emit_load) begin
      out_item_q <= '{out_x0: test_q.x0, out_y0: test_q.y0,
                      out_x1: test_q.x1, out_y1: test_q.y1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- cell ring ----------------
  // Append shifts toward higher cells; test rotates toward cell 0.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      sem_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .prev_i (in_seg),
        .next_i (cell_seg[(k + 1) % TABLE_DEPTH]),
        .seg_o  (cell_seg[k])
      );
    end else begin : g_body
      sem_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (cell_ctrl),
        .prev_i (cell_seg[k - 1]),
        .next_i (cell_seg[(k + 1) % TABLE_DEPTH]),
        .seg_o  (cell_seg[k])
      );
    end
  end

  sem_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (feed_valid),
    .seg_i   (test_q),
    .ref_i   (cell_seg[0]),
    .thr_i   (thr_q),
    .hit_o   (hit)
  );

  // ---------------- assertions ----------------
  `SEM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(TABLE_DEPTH), "table count over depth")
  `SEM_ASSERT(a_hit_in_run, clk_i, rst_ni, hit |-> (state_q == S_RUN), "distance hit outside test run")
  `SEM_ASSERT(a_test_start, clk_i, rst_ni, start_test |=> (state_q == S_RUN) && (step_q == '0), "test did not start at step zero")
  `SEM_ASSERT(a_count_hold, clk_i, rst_ni, (state_q != S_IDLE) |=> $stable(count_q), "table count changed during a test")
  `SEM_ASSERT(a_emit_empty, clk_i, rst_ni, emit_load |-> out_free, "result loaded over a pending item")

endmodule

`default_nettype wire

// ===== bench/tb_segment_endpoint_matcher.sv =====
// Self-checking testbench for the segment endpoint matcher: table, test and threshold paths.
`default_nettype none

module tb_segment_endpoint_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + DIST_LAT + 40;
  localparam int LONG_HOLD    = 1500;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam logic [PADDR_W-1:0] ADDR_THRESH = PADDR_W'({REG_IDX_THRESH, 2'b00});

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  segment_endpoint_matcher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block: reference table, fill level and threshold.
  seg_t             shadow_refs [TABLE_DEPTH];
  int               shadow_count = 0;
  logic [THR_W-1:0] thr_model = THR_RESET;

  in_item_t  pending_items [$];
  out_item_t unmatched_q [$];
  seg_t      gen_refs [$];

  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int tests_cnt = 0;
  int matched_cnt = 0;
  int results_cnt = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int in_idle_pct = 10;
  int out_idle_pct = 10;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic longint unsigned endpoint_dist2(coord_t ax, coord_t ay,
                                                      coord_t bx, coord_t by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax > bx) ? longint'(ax - bx) : longint'(bx - ax);
    dy = (ay > by) ? longint'(ay - by) : longint'(by - ay);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit seg_is_matched(in_item_t it);
    longint unsigned fwd;
    longint unsigned rev;
    seg_t r;
    for (int i = 0; i < shadow_count; i++) begin
      r = shadow_refs[i];
      fwd = endpoint_dist2(it.seg_x0, it.seg_y0, r.x0, r.y0) +
            endpoint_dist2(it.seg_x1, it.seg_y1, r.x1, r.y1);
      rev = endpoint_dist2(it.seg_x0, it.seg_y0, r.x1, r.y1) +
            endpoint_dist2(it.seg_x1, it.seg_y1, r.x0, r.y0);
      if (fwd < longint'(thr_model) || rev < longint'(thr_model)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_item(in_item_t it);
    out_item_t res;
    case (it.func)
      FUNC_CLEAR: begin
        shadow_count = 0;
      end
      FUNC_APPEND: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_refs[shadow_count] = '{it.seg_x0, it.seg_y0, it.seg_x1, it.seg_y1};
          shadow_count++;
        end
      end
      FUNC_TEST: begin
        tests_cnt++;
        if (seg_is_matched(it)) begin
          matched_cnt++;
        end else begin
          res = '{it.seg_x0, it.seg_y0, it.seg_x1, it.seg_y1};
          unmatched_q.insert(unmatched_q.size(), res);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sender: hold the item until accepted, then offer the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        apply_item(in_item);
        accepted_cnt++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest unmatched segment.
  always @(posedge clk_i) begin : receiver
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_ready) begin
        results_cnt++;
        if (unmatched_q.size() == 0) begin
          $display("%0t: expected no item got %0d,%0d,%0d,%0d", $time, out_item_o.out_x0,
                   out_item_o.out_y0, out_item_o.out_x1, out_item_o.out_y1);
          errors++;
        end else begin
          want = unmatched_q.pop_front();
          check_field("out_x0", want.out_x0, out_item_o.out_x0);
          check_field("out_y0", want.out_y0, out_item_o.out_y0);
          check_field("out_x1", want.out_x1, out_item_o.out_x1);
          check_field("out_y1", want.out_y1, out_item_o.out_y1);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_cnt >= 30) begin
        // Stall long enough for the block to back up its input.
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, unmatched_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [FUNC_W-1:0] f, int x0, int y0,
                                         int x1, int y1);
    in_item_t it;
    it.func   = f;
    it.seg_x0 = coord_t'(x0);
    it.seg_y0 = coord_t'(y0);
    it.seg_x1 = coord_t'(x1);
    it.seg_y1 = coord_t'(y1);
    return it;
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    s.x0 = coord_t'(rand_coord());
    s.y0 = coord_t'(rand_coord());
    s.x1 = coord_t'(rand_coord());
    s.y1 = coord_t'(rand_coord());
    return s;
  endfunction

  function automatic coord_t jitter(coord_t c, int rad);
    int v;
    v = int'(c) + int'($urandom_range(2 * rad)) - rad;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  task automatic queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
    pushed_cnt++;
  endtask

  task automatic queue_seg(logic [FUNC_W-1:0] f, seg_t s);
    queue_item(make_item(f, s.x0, s.y0, s.x1, s.y1));
  endtask

  task automatic queue_append(seg_t s);
    queue_seg(FUNC_APPEND, s);
    if (gen_refs.size() < TABLE_DEPTH) gen_refs.insert(gen_refs.size(), s);
  endtask

  // Wait until every item is in and every result out, then let a matched test finish.
  task automatic drain();
    while (accepted_cnt != pushed_cnt || unmatched_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [THR_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_THRESH;
    pwdata  <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready !== 1'b1) begin
      $display("%0t: pready expected 1 got %b", $time, pready);
      errors++;
    end
    if (!wr && prdata !== PDATA_W'(val)) begin
      $display("%0t: threshold readback expected %0d got %0d", $time, val, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_threshold(logic [THR_W-1:0] val);
    drain();
    apb_access(1'b1, val);
    thr_model = val;
    apb_access(1'b0, val);
  endtask

  task automatic gen_phase(int n, bit fill);
    int   done_n;
    int   rad;
    int   r;
    seg_t s;
    seg_t pick;
    done_n = 0;
    rad = int'($sqrt(real'(thr_model)) / 2.0) + 1;
    if (rad > COORD_MAX) rad = COORD_MAX;
    if (fill) begin
      // Overflow the table so the last appends get dropped.
      queue_seg(FUNC_CLEAR, rand_seg());
      gen_refs.delete();
      for (int k = 0; k < TABLE_DEPTH + 3; k++) queue_append(rand_seg());
      done_n = TABLE_DEPTH + 4;
    end
    while (done_n < n) begin
      r = $urandom_range(99);
      s = rand_seg();
      if (r < 4) begin
        queue_seg(FUNC_CLEAR, s);
        gen_refs.delete();
        done_n++;
      end else if (r < 7) begin
        queue_seg(FUNC_UNUSED, s);
      end else if (r < 45) begin
        queue_append(s);
        done_n++;
      end else begin
        if (gen_refs.size() != 0 && $urandom_range(9) < 6) begin
          pick = gen_refs[$urandom_range(gen_refs.size() - 1)];
          if ($urandom_range(4) != 0) begin
            pick.x0 = jitter(pick.x0, rad);
            pick.y0 = jitter(pick.y0, rad);
            pick.x1 = jitter(pick.x1, rad);
            pick.y1 = jitter(pick.y1, rad);
          end
          if ($urandom_range(1)) s = '{pick.x1, pick.y1, pick.x0, pick.y0};
          else s = pick;
        end
        queue_seg(FUNC_TEST, s);
        done_n++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, unused code, exact and reversed hits, threshold edge.
    queue_item(make_item(FUNC_TEST, 0, 0, COORD_MAX, COORD_MAX));
    queue_item(make_item(FUNC_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_item(make_item(FUNC_APPEND, 100, 100, 200, 200));
    queue_item(make_item(FUNC_TEST, 100, 100, 200, 200));
    queue_item(make_item(FUNC_TEST, 200, 200, 100, 100));
    queue_item(make_item(FUNC_TEST, 120, 110, 200, 200));
    queue_item(make_item(FUNC_TEST, 121, 107, 203, 200));
    queue_item(make_item(FUNC_APPEND, COORD_MAX, 0, 0, COORD_MAX));
    queue_item(make_item(FUNC_TEST, 0, COORD_MAX, COORD_MAX, 0));
    queue_item(make_item(FUNC_TEST, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_item(make_item(FUNC_CLEAR, COORD_MAX, 0, COORD_MAX, 0));
    queue_item(make_item(FUNC_TEST, 100, 100, 200, 200));

    // Zero threshold: even an identical segment comes out.
    set_threshold('0);
    queue_item(make_item(FUNC_APPEND, 0, 0, 0, 0));
    queue_item(make_item(FUNC_TEST, 0, 0, 0, 0));

    // Largest threshold: the farthest segment still matches.
    set_threshold(THR_MAX);
    queue_item(make_item(FUNC_TEST, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    queue_item(make_item(FUNC_CLEAR, 0, 0, 0, 0));
    queue_item(make_item(FUNC_TEST, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    gen_refs.delete();

    set_threshold(THR_W'(37));
    gen_phase(190, 1'b0);

    set_threshold(THR_W'(1));
    in_idle_pct  = 0;
    out_idle_pct = 0;
    gen_phase(190, 1'b0);

    set_threshold(THR_W'(4000));
    in_idle_pct  = 10;
    out_idle_pct = 10;
    gen_phase(340, 1'b1);

    set_threshold(THR_MAX);
    gen_phase(190, 1'b0);

    set_threshold(THR_W'($urandom_range(32'h3FF_FFFF)));
    gen_phase(190, 1'b0);

    set_threshold(THR_RESET);
    gen_phase(190, 1'b0);

    drain();
    $display("Covered %0d items: %0d tests, %0d matched, %0d unmatched results checked.",
             accepted_cnt, tests_cnt, matched_cnt, results_cnt);
    $display("Thresholds swept from zero to full scale, with table overflow and output stall.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
